// File: hdl/tmwf_pkg.sv
// Package: shared defaults and control bundles of the trimmed mean window filter.
package tmwf_pkg;

  localparam int SHIFT_DEF       = 2;
  localparam int SAMPLE_BITS_DEF = 12;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic take;
  } acc_ctrl_t;

endpackage

// File: hdl/tmwf_cell.sv
// Module: one window cell, a sample register that loads from its left neighbor.
module tmwf_cell #(
  parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tmwf_pkg::cell_ctrl_t   ctrl,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] dout
);

  logic [SAMPLE_BITS-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.load || ctrl.rotate) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

// File: hdl/tmwf_accum.sv
// Module: running min, max and sum over the sweep, and the trimmed mean.
module tmwf_accum #(
  parameter int SHIFT       = tmwf_pkg::SHIFT_DEF,
  parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  tmwf_pkg::acc_ctrl_t    ctrl,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] result
);

  localparam int SUM_BITS = SAMPLE_BITS + SHIFT + 1;

  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SUM_BITS-1:0]    trimmed;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum <= '0;
      lo  <= '1;
      hi  <= '0;
    end else if (ctrl.take) begin
      sum <= sum + SUM_BITS'(din);
      if (din < lo) begin
        lo <= din;
      end
      if (din > hi) begin
        hi <= din;
      end
    end
  end

  assign trimmed = sum - SUM_BITS'(lo) - SUM_BITS'(hi);
  assign result  = trimmed[SHIFT +: SAMPLE_BITS];

endmodule

// File: hdl/trimmed_mean_window_filter.sv
// Top level: trimmed mean moving average filter over a rotating chain of sample cells.
// Each accepted sample enters the head of a chain of 2^SHIFT+2 cells (reset to zero) and
// pushes the oldest one out. The chain then rotates once around, one cell per cycle, while
// an accumulator collects sum, minimum and maximum from its tail; the result is the sum
// without one minimum and one maximum, shifted right by SHIFT. A new sample is taken only
// once the rotation over the chain is done and its result is registered, which waits while
// a stalled earlier result still holds the output; the result sits in an output register,
// so the next sample is taken while it waits.
module trimmed_mean_window_filter #(
  parameter int SHIFT       = tmwf_pkg::SHIFT_DEF,
  parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] filtered
);

  localparam int WINDOW_LEN = (1 << SHIFT) + 2;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic                   accept;
  logic                   sweep;
  logic                   finish;
  tmwf_pkg::cell_ctrl_t   cell_ctrl;
  tmwf_pkg::acc_ctrl_t    acc_ctrl;
  logic [SAMPLE_BITS-1:0] chain [WINDOW_LEN+1];
  logic [SAMPLE_BITS-1:0] result;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign sweep    = busy && (cnt != CNT_W'(WINDOW_LEN));
  assign finish   = busy && (cnt == CNT_W'(WINDOW_LEN)) && !(out_valid && out_stall);

  assign cell_ctrl.load   = accept;
  assign cell_ctrl.rotate = sweep;
  assign acc_ctrl.clear   = accept;
  assign acc_ctrl.take    = sweep;

  assign chain[0] = accept ? sample : chain[WINDOW_LEN];

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    tmwf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .ctrl(cell_ctrl),
      .din (chain[k]),
      .dout(chain[k+1])
    );
  end

  tmwf_accum #(
    .SHIFT      (SHIFT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk   (clk),
    .ctrl  (acc_ctrl),
    .din   (chain[WINDOW_LEN]),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (sweep) begin
        cnt <= cnt + 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
        cnt  <= '0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      filtered <= result;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && (cnt == '0))
    else $error("sweep did not start after input transaction");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW_LEN))
    else $error("sweep counter out of range");

  a_result_from_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && !busy)
    else $error("result appeared without a finished sweep");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cnt == '0))
    else $error("sweep counter not cleared while idle");

endmodule
